FILE: rtl/core/phwd_pkg.sv
package phwd_pkg;

   // Default geometry of one sector.
   localparam int SECTORS = 10;
   localparam int ROWS    = 928;
   localparam int COLUMNS = 960;

   // Chip ids run from 1 to this value; ten sensors sit on each ladder.
   localparam int CHIP_ID_MAX        = 40;
   localparam int SENSORS_PER_LADDER = 10;

   // Pixels that one word can fire: four per half.
   localparam int HITS_PER_WORD = 8;

   // Word queue between the front and back ends (power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream payload widths.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // Configuration registers.
   localparam int CSR_DATA_W = 40;
   typedef enum logic [0:0] {
      CSR_MASK_ENABLE = 1'b0,
      CSR_GOOD_MASK   = 1'b1
   } csr_index_type;

   // One decoded word waiting for the back end. Row and overflow count are the
   // values after the low half, which is what every hit of the word sees.
   typedef struct packed {
      logic [3:0]               sector;
      logic [2:0]               ladder;
      logic [3:0]               sensor;
      logic [9:0]               row;
      logic [15:0]              overflow;
      logic [9:0]               col_lo;
      logic [9:0]               col_hi;
      logic [HITS_PER_WORD-1:0] hit_mask;
   } entry_type;

endpackage

FILE: rtl/core/phwd_front.sv
module phwd_front #(
   parameter int SECTORS = phwd_pkg::SECTORS,
   parameter int ROWS    = phwd_pkg::ROWS,
   parameter int COLUMNS = phwd_pkg::COLUMNS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               word_valid,
   input  logic [31:0]                        data_word,
   input  logic [3:0]                         sector_number,
   input  logic                               frame_start,
   input  logic                               queue_not_full,
   input  logic                               mask_enable,
   input  logic [phwd_pkg::CHIP_ID_MAX-1:0]   good_mask,
   output logic                               word_ready,
   output logic                               push,
   output phwd_pkg::entry_type                push_entry
);

   logic [9:0]  current_row_ff, current_row_in;
   logic [15:0] overflow_ff, overflow_in;

   logic [15:0] lo_half, hi_half;
   logic [5:0]  chip_id, id_m1;
   logic        id_ok, sensor_good, sector_ok, row_ok;
   logic [2:0]  ladder;
   logic [3:0]  sensor;
   logic [9:0]  row_after_lo;
   logic [15:0] ovf_cleared, ovf_after_lo, ovf_after_hi;
   logic [phwd_pkg::HITS_PER_WORD-1:0] hit_mask;
   logic        accept;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   assign accept     = word_valid && queue_not_full;
   assign word_ready = queue_not_full;

   // Chip id and its place on the sector.
   always_comb begin
      lo_half = data_word[15:0];
      hi_half = data_word[31:16];
      chip_id = {hi_half[15:13], lo_half[15:13]};
      id_ok   = (chip_id != 6'd0) && (chip_id <= 6'(phwd_pkg::CHIP_ID_MAX));
      id_m1   = chip_id - 6'd1;
      if (id_m1 < 6'd10) begin
         ladder = 3'd1;
         sensor = 4'(id_m1 + 6'd1);
      end else if (id_m1 < 6'd20) begin
         ladder = 3'd2;
         sensor = 4'(id_m1 - 6'd9);
      end else if (id_m1 < 6'd30) begin
         ladder = 3'd3;
         sensor = 4'(id_m1 - 6'd19);
      end else begin
         ladder = 3'd4;
         sensor = 4'(id_m1 - 6'd29);
      end
      sensor_good = !mask_enable || good_mask[id_m1];
      sector_ok   = (sector_number != 4'd0) && (sector_number <= 4'(SECTORS));
   end

   // Row and overflow state through both halves.
   always_comb begin
      ovf_cleared  = frame_start ? 16'd0 : overflow_ff;
      row_after_lo = lo_half[12] ? lo_half[11:2] : current_row_ff;
      ovf_after_lo = (lo_half[12] && lo_half[1]) ? sat_inc(ovf_cleared) : ovf_cleared;
      ovf_after_hi = (hi_half[12] && hi_half[1]) ? sat_inc(ovf_after_lo) : ovf_after_lo;
      row_ok       = row_after_lo < 10'(ROWS);
      if (id_ok) begin
         current_row_in = hi_half[12] ? hi_half[11:2] : row_after_lo;
         overflow_in    = ovf_after_hi;
      end else begin
         current_row_in = current_row_ff;
         overflow_in    = ovf_cleared;
      end
   end

   // Which pixels of each run survive the checks.
   always_comb begin
      logic [15:0] half;
      logic [10:0] col_sum;
      hit_mask = '0;
      for (int h = 0; h < 2; h++) begin
         half = (h == 0) ? lo_half : hi_half;
         for (int c = 0; c < 4; c++) begin
            col_sum = {1'b0, half[11:2]} + 11'(c);
            hit_mask[h*4+c] = id_ok && sector_ok && sensor_good && row_ok &&
                              !half[12] && (2'(c) <= half[1:0]) &&
                              (col_sum < 11'(COLUMNS));
         end
      end
   end

   // Words that fire nothing only move the state.
   assign push = accept && (hit_mask != '0);

   always_comb begin
      push_entry.sector   = sector_number;
      push_entry.ladder   = ladder;
      push_entry.sensor   = sensor;
      push_entry.row      = row_after_lo;
      push_entry.overflow = ovf_after_lo;
      push_entry.col_lo   = lo_half[11:2];
      push_entry.col_hi   = hi_half[11:2];
      push_entry.hit_mask = hit_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_row_ff <= '0;
         overflow_ff    <= '0;
      end else if (accept) begin
         current_row_ff <= current_row_in;
         overflow_ff    <= overflow_in;
      end
   end

endmodule

FILE: rtl/core/phwd_queue.sv
module phwd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  phwd_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                not_full,
   output logic                not_empty,
   output phwd_pkg::entry_type head
);

   phwd_pkg::entry_type              mem_ff [phwd_pkg::QUEUE_DEPTH];
   logic [phwd_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [phwd_pkg::QCNT_W-1:0]      count_ff;

   assign not_full  = count_ff != phwd_pkg::QCNT_W'(phwd_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   // Storage; pointers wrap naturally since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + phwd_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + phwd_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + phwd_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - phwd_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/phwd_back.sv
module phwd_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_not_empty,
   input  phwd_pkg::entry_type                   head,
   output logic                                  pop,
   output logic                                  hit_valid,
   input  logic                                  hit_ready,
   output logic [phwd_pkg::RSP_DATA_W-1:0]       hit_data,
   output logic                                  hit_last
);

   logic                       work_valid_ff, work_valid_in;
   phwd_pkg::entry_type        work_ff, work_in;
   logic                       out_valid_ff, out_valid_in;
   logic [phwd_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;

   logic                                  out_load, emit;
   logic [phwd_pkg::HITS_PER_WORD-1:0]    low_bit, remain;
   logic [2:0]                            pix;
   logic [9:0]                            col_base, column;

   // Output register frees itself when empty or when its beat is taken.
   assign out_load = !out_valid_ff || hit_ready;
   assign emit     = work_valid_ff && out_load;

   // Pick the lowest pending pixel of the word in work.
   always_comb begin
      low_bit = work_ff.hit_mask & (~work_ff.hit_mask + phwd_pkg::HITS_PER_WORD'(1));
      remain  = work_ff.hit_mask & ~low_bit;
      pix     = '0;
      for (int i = 0; i < phwd_pkg::HITS_PER_WORD; i++) begin
         if (low_bit[i]) begin
            pix = 3'(i);
         end
      end
      col_base = pix[2] ? work_ff.col_hi : work_ff.col_lo;
      column   = col_base + 10'(pix[1:0]);
   end

   // Take the next word when none is in work or once the current one gives its last hit.
   assign pop = queue_not_empty && (!work_valid_ff || (emit && remain == '0));

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (pop) begin
         work_in       = head;
         work_valid_in = 1'b1;
      end else if (emit) begin
         work_in.hit_mask = remain;
         work_valid_in    = remain != '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = emit;
         out_data_in  = {1'b0, work_ff.overflow, column, work_ff.row,
                         work_ff.sensor, work_ff.ladder, work_ff.sector};
         out_last_in  = remain == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      work_ff     <= work_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign hit_valid = out_valid_ff;
   assign hit_data  = out_data_ff;
   assign hit_last  = out_last_ff;

endmodule

FILE: rtl/core/pixel_sensor_hit_word_decoder_top.sv
// Pixel hit word decoder. Each request beat carries one 32-bit pixel word of a
// sector; the block emits one response beat per fired pixel, up to eight per
// word, with tlast on the last hit of the word. A word is taken every cycle
// while the four-word queue between the decoding front end and the hit
// back end has room; the back end delivers one hit per cycle while rsp_tready
// is high, and a word that fires nothing only moves the front-end state. With
// the back end idle, the first hit of a word passes through the queue, the work
// register and the output register before it shows on the response side. Row
// and overflow state are updated at the front, so they follow the order of
// accepted words. Write the mask registers only while no hits are pending.
module pixel_sensor_hit_word_decoder_top #(
   parameter int SECTORS = phwd_pkg::SECTORS,
   parameter int ROWS    = phwd_pkg::ROWS,
   parameter int COLUMNS = phwd_pkg::COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // data_word [31:0], sector_number [35:32], zero fill [39:36]
   input  logic [phwd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // frame_start [0]
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit_sector [3:0], hit_ladder [6:4], hit_sensor [10:7], hit_row [20:11],
   // hit_column [30:21], overflow_total [46:31], zero fill [47]
   output logic [phwd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  phwd_pkg::csr_index_type             csr_index,
   input  logic [phwd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                                mask_enable_ff;
   logic [phwd_pkg::CHIP_ID_MAX-1:0]    good_mask_ff;

   logic                q_push, q_pop, q_not_full, q_not_empty;
   phwd_pkg::entry_type q_push_entry, q_head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_enable_ff <= 1'b0;
         good_mask_ff   <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            phwd_pkg::CSR_MASK_ENABLE: mask_enable_ff <= csr_wdata[0];
            phwd_pkg::CSR_GOOD_MASK:
               good_mask_ff <= csr_wdata[phwd_pkg::CHIP_ID_MAX-1:0];
            default: mask_enable_ff <= mask_enable_ff;
         endcase
      end
   end

   phwd_front #(
      .SECTORS (SECTORS),
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .word_valid     (req_tvalid),
      .data_word      (req_tdata[31:0]),
      .sector_number  (req_tdata[35:32]),
      .frame_start    (req_tuser[0]),
      .queue_not_full (q_not_full),
      .mask_enable    (mask_enable_ff),
      .good_mask      (good_mask_ff),
      .word_ready     (req_tready),
      .push           (q_push),
      .push_entry     (q_push_entry)
   );

   phwd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .not_full   (q_not_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   phwd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (q_not_empty),
      .head            (q_head),
      .pop             (q_pop),
      .hit_valid       (rsp_tvalid),
      .hit_ready       (rsp_tready),
      .hit_data        (rsp_tdata),
      .hit_last        (rsp_tlast)
   );

   // Every delivered hit lies inside the sector geometry.
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:11] < 10'(ROWS)) && (rsp_tdata[30:21] < 10'(COLUMNS)))
      else $error("hit outside the pixel matrix");

   a_sector_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] != 4'd0) && (rsp_tdata[3:0] <= 4'(SECTORS)))
      else $error("hit from a sector out of range");

   a_place_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:4] != 3'd0) && (rsp_tdata[6:4] <= 3'd4) &&
                     (rsp_tdata[10:7] != 4'd0) && (rsp_tdata[10:7] <= 4'd10))
      else $error("hit with bad ladder or sensor");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat right after reset");

endmodule
